FILE: design/vn_pkg.sv
// Package for the 2D vector normaliser.
// Holds the pipeline depths, field widths and the per-stage sideband struct; no dependencies.
package vn_pkg;
    localparam int SQ_STEPS  = 30;
    localparam int DIV_STEPS = 15;
    localparam int RAD_W     = 60;
    localparam int REM_W     = 44;
    localparam int LEN_W     = 30;
    localparam int SQ_W      = 32;
    localparam int Q_W       = 15;
    localparam logic [Q_W-1:0] Q14_ONE = 15'd16384;

    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic            zero;
        logic            sx;
        logic            sy;
    } t_side;
endpackage

FILE: design/vector2_normalizer.sv
// Top level of the 2D vector normaliser: squares, 30-step square root, two 15-step dividers.
// Depends on vn_pkg.
//
// Input channel: i_valid / o_stall with i_vec_x, i_vec_y (signed 16 bit).
// Output channel: o_valid / i_stall with o_norm_x, o_norm_y (Q1.14),
// o_length_q14, o_length_squared and o_zero_vector.
// A beat is taken when valid is high and stall is low.
// Path from input beat to output beat: multiply, sum,
// one stage per root bit, one stage per quotient bit, output register.
// Throughput: one beat per cycle unless the pipeline is held; every stage
// has its own registers and a valid bit travels with each vector.
// The whole pipeline holds while a result waits and i_stall is high;
// o_stall is raised only then, so no beat is lost or repeated.
// Reset clears all valid bits; no result is in flight afterwards.
module vector2_normalizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_vec_x,
    input  logic signed [15:0]            i_vec_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [15:0]            o_norm_x,
    output logic signed [15:0]            o_norm_y,
    output logic [vn_pkg::LEN_W-1:0]      o_length_q14,
    output logic [vn_pkg::SQ_W-1:0]       o_length_squared,
    output logic                          o_zero_vector
);
    import vn_pkg::*;

    logic en;

    logic               r_a_vld;
    logic signed [15:0] r_a_x, r_a_y;
    logic [30:0]        r_a_xx, r_a_yy;

    logic               r_s_vld [0:SQ_STEPS];
    logic [RAD_W-1:0]   r_s_v   [0:SQ_STEPS];
    logic [RAD_W-1:0]   r_s_res [0:SQ_STEPS];
    logic signed [15:0] r_s_x   [0:SQ_STEPS];
    logic signed [15:0] r_s_y   [0:SQ_STEPS];
    t_side              r_s_sd  [0:SQ_STEPS];
    logic [RAD_W-1:0]   n_s_v   [1:SQ_STEPS];
    logic [RAD_W-1:0]   n_s_res [1:SQ_STEPS];

    logic               r_d_vld [0:DIV_STEPS];
    logic [LEN_W-1:0]   r_d_len [0:DIV_STEPS];
    logic [REM_W-1:0]   r_d_rx  [0:DIV_STEPS];
    logic [REM_W-1:0]   r_d_ry  [0:DIV_STEPS];
    logic [Q_W-1:0]     r_d_qx  [0:DIV_STEPS];
    logic [Q_W-1:0]     r_d_qy  [0:DIV_STEPS];
    t_side              r_d_sd  [0:DIV_STEPS];
    logic [REM_W-1:0]   n_d_rx  [1:DIV_STEPS];
    logic [REM_W-1:0]   n_d_ry  [1:DIV_STEPS];
    logic [Q_W-1:0]     n_d_qx  [1:DIV_STEPS];
    logic [Q_W-1:0]     n_d_qy  [1:DIV_STEPS];

    logic [15:0]        mag_x, mag_y;
    logic [Q_W-1:0]     cl_x, cl_y;
    logic [Q_W:0]       n_nx, n_ny;

    logic               r_o_vld;

    assign en      = ~(r_o_vld & i_stall);
    assign o_stall = ~en;
    assign o_valid = r_o_vld;

    // root: one result bit per stage
    always_comb begin
        for (int i = 1; i <= SQ_STEPS; i++) begin
            logic [RAD_W-1:0] bitv, t;
            bitv = RAD_W'(1) << (2 * (SQ_STEPS - i));
            t    = r_s_res[i-1] + bitv;
            if (r_s_v[i-1] >= t) begin
                n_s_v[i]   = r_s_v[i-1] - t;
                n_s_res[i] = (r_s_res[i-1] >> 1) + bitv;
            end else begin
                n_s_v[i]   = r_s_v[i-1];
                n_s_res[i] = r_s_res[i-1] >> 1;
            end
        end
    end

    assign mag_x = r_s_x[SQ_STEPS][15] ? 16'(-r_s_x[SQ_STEPS]) : r_s_x[SQ_STEPS];
    assign mag_y = r_s_y[SQ_STEPS][15] ? 16'(-r_s_y[SQ_STEPS]) : r_s_y[SQ_STEPS];

    // quotient: one bit per stage, bit DIV_STEPS-j at stage j
    always_comb begin
        for (int j = 1; j <= DIV_STEPS; j++) begin
            logic [REM_W-1:0] dsh;
            dsh = REM_W'(r_d_len[j-1]) << (DIV_STEPS - j);
            n_d_rx[j] = r_d_rx[j-1];
            n_d_qx[j] = r_d_qx[j-1];
            n_d_ry[j] = r_d_ry[j-1];
            n_d_qy[j] = r_d_qy[j-1];
            if (r_d_rx[j-1] >= dsh) begin
                n_d_rx[j] = r_d_rx[j-1] - dsh;
                n_d_qx[j][DIV_STEPS-j] = 1'b1;
            end
            if (r_d_ry[j-1] >= dsh) begin
                n_d_ry[j] = r_d_ry[j-1] - dsh;
                n_d_qy[j][DIV_STEPS-j] = 1'b1;
            end
        end
    end

    assign cl_x = (r_d_qx[DIV_STEPS] > Q14_ONE) ? Q14_ONE : r_d_qx[DIV_STEPS];
    assign cl_y = (r_d_qy[DIV_STEPS] > Q14_ONE) ? Q14_ONE : r_d_qy[DIV_STEPS];
    assign n_nx = r_d_sd[DIV_STEPS].sx ? (Q_W+1)'(-{1'b0, cl_x}) : {1'b0, cl_x};
    assign n_ny = r_d_sd[DIV_STEPS].sy ? (Q_W+1)'(-{1'b0, cl_y}) : {1'b0, cl_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
            for (int i = 0; i <= SQ_STEPS; i++) r_s_vld[i] <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++) r_d_vld[j] <= 1'b0;
        end else if (en) begin
            r_a_vld    <= i_valid;
            r_s_vld[0] <= r_a_vld;
            for (int i = 1; i <= SQ_STEPS; i++) r_s_vld[i] <= r_s_vld[i-1];
            r_d_vld[0] <= r_s_vld[SQ_STEPS];
            for (int j = 1; j <= DIV_STEPS; j++) r_d_vld[j] <= r_d_vld[j-1];
            r_o_vld    <= r_d_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x  <= i_vec_x;
            r_a_y  <= i_vec_y;
            r_a_xx <= 31'(unsigned'(32'(i_vec_x * i_vec_x)));
            r_a_yy <= 31'(unsigned'(32'(i_vec_y * i_vec_y)));

            r_s_v[0]     <= {SQ_W'(r_a_xx) + SQ_W'(r_a_yy), 28'd0};
            r_s_res[0]   <= '0;
            r_s_x[0]     <= r_a_x;
            r_s_y[0]     <= r_a_y;
            r_s_sd[0].sq   <= SQ_W'(r_a_xx) + SQ_W'(r_a_yy);
            r_s_sd[0].zero <= (r_a_x == 16'sd0) && (r_a_y == 16'sd0);
            r_s_sd[0].sx   <= r_a_x[15];
            r_s_sd[0].sy   <= r_a_y[15];
            for (int i = 1; i <= SQ_STEPS; i++) begin
                r_s_v[i]   <= n_s_v[i];
                r_s_res[i] <= n_s_res[i];
                r_s_x[i]   <= r_s_x[i-1];
                r_s_y[i]   <= r_s_y[i-1];
                r_s_sd[i]  <= r_s_sd[i-1];
            end

            r_d_len[0] <= LEN_W'(r_s_res[SQ_STEPS]);
            r_d_rx[0]  <= {mag_x, 28'd0};
            r_d_ry[0]  <= {mag_y, 28'd0};
            r_d_qx[0]  <= '0;
            r_d_qy[0]  <= '0;
            r_d_sd[0]  <= r_s_sd[SQ_STEPS];
            for (int j = 1; j <= DIV_STEPS; j++) begin
                r_d_len[j] <= r_d_len[j-1];
                r_d_rx[j]  <= n_d_rx[j];
                r_d_ry[j]  <= n_d_ry[j];
                r_d_qx[j]  <= n_d_qx[j];
                r_d_qy[j]  <= n_d_qy[j];
                r_d_sd[j]  <= r_d_sd[j-1];
            end

            o_length_q14     <= r_d_len[DIV_STEPS];
            o_length_squared <= r_d_sd[DIV_STEPS].sq;
            o_zero_vector    <= r_d_sd[DIV_STEPS].zero;
            if (r_d_sd[DIV_STEPS].zero || r_d_len[DIV_STEPS] == '0) begin
                o_norm_x <= '0;
                o_norm_y <= '0;
            end else begin
                o_norm_x <= signed'(16'(n_nx));
                o_norm_y <= signed'(16'(n_ny));
            end
        end
    end

    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |-> (o_norm_x == 16'sd0 && o_norm_y == 16'sd0))
        else $error("zero vector with non-zero normal");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm_x <= 16'sd16384 && o_norm_x >= -16'sd16384
                     && o_norm_y <= 16'sd16384 && o_norm_y >= -16'sd16384))
        else $error("normal component out of range");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_length_q14 == '0) == (o_length_squared == '0)))
        else $error("length and squared length disagree on zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_length_squared)))
        else $error("stalled result changed");
endmodule
